FILE: rtl/pmm_pkg.sv
// Shared types, constants and the microcode ROM of the steering PID motor mixer.
package pmm_pkg;

	// Fixed-point formats
	localparam int ERR_FRAC_BITS  = 8;
	localparam int GAIN_FRAC_BITS = 12;

	// Field and register widths
	localparam int ERR_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int LIMIT_W   = 15;
	localparam int SPEED_W   = 8;
	localparam int PERIOD_W  = 20;
	localparam int PULSE_W   = 20;
	localparam int COR_W     = 16;
	localparam int ACC_SUM_W = ERR_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int OUT_DATA_W = COR_W + 4 * PULSE_W;

	// Datapath widths
	localparam int MUL_W   = 27;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int RAW_W   = 36;
	localparam int GAIN_RND = (1 << GAIN_FRAC_BITS) - 1;
	localparam int TGT_W   = ((SPEED_W + ERR_FRAC_BITS > COR_W) ?
		(SPEED_W + ERR_FRAC_BITS) : COR_W) + 1;
	localparam int DUTY_W    = 7;
	localparam int DUTY_FULL = 100;

	// duty * period / 100 is taken as ((duty * period) >> 2) / 25, the last
	// division by an exact reciprocal multiply
	localparam int DP_W      = DUTY_W + PERIOD_W;
	localparam int DIV_SHIFT = 2;
	localparam int DIV_D     = DUTY_FULL >> DIV_SHIFT;
	localparam int DIV_K     = DP_W - DIV_SHIFT + 5;
	localparam longint RECIP_M = ((64'sd1 <<< DIV_K) + DIV_D - 1) / DIV_D;

	// Reset values of the registers
	localparam logic [GAIN_W-1:0]   KP_RST     = 16'd2458;
	localparam logic [GAIN_W-1:0]   KI_RST     = 16'd41;
	localparam logic [GAIN_W-1:0]   KD_RST     = 16'd5325;
	localparam logic [LIMIT_W-1:0]  OLIM_RST   = 15'd10240;
	localparam logic [LIMIT_W-1:0]  ILIM_RST   = 15'd768;
	localparam logic signed [SPEED_W-1:0] BASE_RST = 8'sd20;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd83333;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OLIM   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ILIM   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd6;

	typedef struct packed {
		logic [GAIN_W-1:0]          kp_gain;
		logic [GAIN_W-1:0]          ki_gain;
		logic [GAIN_W-1:0]          kd_gain;
		logic [LIMIT_W-1:0]         output_limit;
		logic [LIMIT_W-1:0]         integral_limit;
		logic signed [SPEED_W-1:0]  base_speed;
		logic [PERIOD_W-1:0]        pwm_period;
	} cfg_t;

	// Microcode
	localparam int PC_W = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_INTEG,
		OP_RAW_CLR,
		OP_RAW_ADD,
		OP_ROUND,
		OP_COR,
		OP_TARGET,
		OP_PULSE,
		OP_DONE
	} op_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_KP_E,
		MUL_KI_ACC,
		MUL_KD_DE,
		MUL_DUTY_PWM,
		MUL_RECIP
	} mul_sel_t;

	typedef enum logic {
		JMP_NEVER,
		JMP_IF_LEFT
	} jmp_t;

	typedef struct packed {
		op_t            op;
		mul_sel_t       mul;
		jmp_t           jmp;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic   start;
		uword_t uw;
	} ctrl_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	localparam logic [PC_W-1:0] PC_SIDE_LOOP = 4'd7;

	function automatic uword_t ucode(logic [PC_W-1:0] pc);
		uword_t w;
		w = '{op: OP_NOP, mul: MUL_NONE, jmp: JMP_NEVER, target: '0};
		case (pc)
			4'd0:  w.op = OP_INTEG;
			4'd1:  begin w.op = OP_RAW_CLR; w.mul = MUL_KP_E; end
			4'd2:  begin w.op = OP_RAW_ADD; w.mul = MUL_KI_ACC; end
			4'd3:  begin w.op = OP_RAW_ADD; w.mul = MUL_KD_DE; end
			4'd4:  w.op = OP_RAW_ADD;
			4'd5:  w.op = OP_ROUND;
			4'd6:  w.op = OP_COR;
			4'd7:  w.op = OP_TARGET;
			4'd8:  w.mul = MUL_DUTY_PWM;
			4'd9:  w.mul = MUL_RECIP;
			4'd10: begin
				w.op = OP_PULSE;
				w.jmp = JMP_IF_LEFT;
				w.target = PC_SIDE_LOOP;
			end
			4'd11: w.op = OP_DONE;
			default: w.op = OP_DONE;
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/pmm_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jump.
module pmm_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_free,
	input  logic              side,
	output pmm_pkg::ctrl_t    ctrl
);

	pmm_pkg::seq_state_t          state_q, state_d;
	logic [pmm_pkg::PC_W-1:0]     pc_q, pc_d;
	pmm_pkg::uword_t              uw;

	assign uw = pmm_pkg::ucode(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmm_pkg::SEQ_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		pc_d       = pc_q;
		in_ready   = 1'b0;
		ctrl.start = 1'b0;
		ctrl.uw    = '{op: pmm_pkg::OP_NOP, mul: pmm_pkg::MUL_NONE,
			jmp: pmm_pkg::JMP_NEVER, target: '0};
		case (state_q)
			pmm_pkg::SEQ_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.start = 1'b1;
					state_d    = pmm_pkg::SEQ_RUN;
					pc_d       = '0;
				end
			end
			pmm_pkg::SEQ_RUN: begin
				ctrl.uw = uw;
				if (uw.op == pmm_pkg::OP_DONE) begin
					// hold on the last step until the output register is free
					if (out_free) begin
						state_d = pmm_pkg::SEQ_IDLE;
						pc_d    = '0;
					end
				end else if (uw.jmp == pmm_pkg::JMP_IF_LEFT && !side) begin
					pc_d = uw.target;
				end else begin
					pc_d = pc_q + 1'b1;
				end
			end
			default: state_d = pmm_pkg::SEQ_IDLE;
		endcase
	end

endmodule

FILE: rtl/pmm_dp.sv
// Datapath: PID state, shared multiplier, clamps, bridge mixing and output register.
module pmm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pmm_pkg::ctrl_t                    ctrl,
	input  pmm_pkg::cfg_t                     cfg,
	input  logic [pmm_pkg::ERR_W-1:0]         err_in,
	output logic                              side,
	output logic                              out_free,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pmm_pkg::OUT_DATA_W-1:0]    out_data
);

	localparam int ACC_SUM_W = pmm_pkg::ACC_SUM_W;
	localparam int RAW_W     = pmm_pkg::RAW_W;
	localparam int TGT_W     = pmm_pkg::TGT_W;
	localparam int MUL_W     = pmm_pkg::MUL_W;

	logic signed [pmm_pkg::ERR_W-1:0]  e_q, acc_q, prev_q;
	logic signed [ACC_SUM_W-1:0]       de_q;
	logic signed [RAW_W-1:0]           raw_q;
	logic signed [pmm_pkg::COR_W-1:0]  cor_q;
	logic signed [pmm_pkg::PROD_W-1:0] prod_q;
	logic                              side_q, fwd_q, out_valid_q;
	logic [pmm_pkg::DUTY_W-1:0]        duty_q;
	logic [pmm_pkg::PULSE_W-1:0]       lf_q, lr_q, rf_q, rr_q;
	logic [pmm_pkg::OUT_DATA_W-1:0]    out_q;

	// integral update
	logic signed [ACC_SUM_W-1:0] acc_sum, ilim_w, acc_new;
	assign acc_sum = ACC_SUM_W'(e_q) + ACC_SUM_W'(acc_q);
	assign ilim_w  = signed'(ACC_SUM_W'(cfg.integral_limit));
	always_comb begin
		if (acc_sum > ilim_w)
			acc_new = ilim_w;
		else if (acc_sum < -ilim_w)
			acc_new = -ilim_w;
		else
			acc_new = acc_sum;
	end

	// shared multiplier operands
	logic signed [MUL_W-1:0] mul_a, mul_b;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.uw.mul)
			pmm_pkg::MUL_KP_E: begin
				mul_a = signed'(MUL_W'(cfg.kp_gain));
				mul_b = MUL_W'(e_q);
			end
			pmm_pkg::MUL_KI_ACC: begin
				mul_a = signed'(MUL_W'(cfg.ki_gain));
				mul_b = MUL_W'(acc_q);
			end
			pmm_pkg::MUL_KD_DE: begin
				mul_a = signed'(MUL_W'(cfg.kd_gain));
				mul_b = MUL_W'(de_q);
			end
			pmm_pkg::MUL_DUTY_PWM: begin
				mul_a = signed'(MUL_W'(duty_q));
				mul_b = signed'(MUL_W'(cfg.pwm_period));
			end
			pmm_pkg::MUL_RECIP: begin
				mul_a = signed'(MUL_W'(prod_q[pmm_pkg::DP_W-1:pmm_pkg::DIV_SHIFT]));
				mul_b = MUL_W'(pmm_pkg::RECIP_M);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// correction: truncate toward zero, then symmetric clamp
	logic signed [RAW_W-1:0] raw_sh, olim_w;
	logic signed [pmm_pkg::COR_W-1:0] cor_new;
	assign raw_sh = raw_q >>> pmm_pkg::GAIN_FRAC_BITS;
	assign olim_w = signed'(RAW_W'(cfg.output_limit));
	always_comb begin
		if (raw_sh > olim_w)
			cor_new = pmm_pkg::COR_W'(olim_w);
		else if (raw_sh < -olim_w)
			cor_new = pmm_pkg::COR_W'(-olim_w);
		else
			cor_new = pmm_pkg::COR_W'(raw_sh);
	end

	// wheel target: left is base - correction, right is base + correction
	logic signed [TGT_W-1:0] speed_fx, cor_w, tgt;
	logic [TGT_W-1:0]        tgt_mag, mag_sh;
	logic [pmm_pkg::DUTY_W-1:0] duty_new;
	logic                    fwd_new;
	assign speed_fx = TGT_W'(cfg.base_speed) <<< pmm_pkg::ERR_FRAC_BITS;
	assign cor_w    = TGT_W'(cor_q);
	assign tgt      = side_q ? (speed_fx + cor_w) : (speed_fx - cor_w);
	assign tgt_mag  = tgt[TGT_W-1] ? unsigned'(-tgt) : unsigned'(tgt);
	assign mag_sh   = tgt_mag >> pmm_pkg::ERR_FRAC_BITS;
	assign fwd_new  = !tgt[TGT_W-1] && (mag_sh != '0);
	assign duty_new = (mag_sh > TGT_W'(pmm_pkg::DUTY_FULL)) ?
		pmm_pkg::DUTY_W'(pmm_pkg::DUTY_FULL) : mag_sh[pmm_pkg::DUTY_W-1:0];

	logic [pmm_pkg::PULSE_W-1:0] pulse;
	assign pulse = prod_q[pmm_pkg::DIV_K +: pmm_pkg::PULSE_W];

	logic out_load;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (ctrl.uw.op == pmm_pkg::OP_DONE) && out_free;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			prev_q      <= '0;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.uw.op == pmm_pkg::OP_INTEG) begin
				acc_q  <= acc_new[pmm_pkg::ERR_W-1:0];
				prev_q <= e_q;
				side_q <= 1'b0;
			end
			if (ctrl.uw.op == pmm_pkg::OP_PULSE)
				side_q <= ~side_q;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (ctrl.start)
			e_q <= signed'(err_in);
		case (ctrl.uw.op)
			pmm_pkg::OP_INTEG:   de_q  <= ACC_SUM_W'(e_q) - ACC_SUM_W'(prev_q);
			pmm_pkg::OP_RAW_CLR: raw_q <= '0;
			pmm_pkg::OP_RAW_ADD: raw_q <= raw_q + signed'(prod_q[RAW_W-1:0]);
			pmm_pkg::OP_ROUND:
				if (raw_q[RAW_W-1])
					raw_q <= raw_q + RAW_W'(pmm_pkg::GAIN_RND);
			pmm_pkg::OP_COR:     cor_q <= cor_new;
			pmm_pkg::OP_TARGET: begin
				duty_q <= duty_new;
				fwd_q  <= fwd_new;
			end
			pmm_pkg::OP_PULSE: begin
				if (!side_q) begin
					lf_q <= fwd_q ? pulse : '0;
					lr_q <= fwd_q ? '0 : pulse;
				end else begin
					rf_q <= fwd_q ? pulse : '0;
					rr_q <= fwd_q ? '0 : pulse;
				end
			end
			default: ;
		endcase
		if (out_load)
			out_q <= {rr_q, rf_q, lr_q, lf_q, cor_q};
	end

	assign side      = side_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: rtl/pid_steering_motor_mixer_unit.sv
// Top level of the steering PID motor mixer: ports, configuration registers, sequencer and datapath.
//
//  channel   | signals                               | role
//  ----------+---------------------------------------+-------------------------------
//  s_axis    | s_axis_tvalid/tready/tdata[15:0]      | error sample in (Q8.8)
//  m_axis    | m_axis_tvalid/tready/tdata[95:0]      | correction and four pulse widths
//  cfg       | cfg_valid/ready, cfg_index, cfg_data  | register writes, always ready
//
// Each sample runs a 12-step microcode program on one shared 27x27 multiplier,
// with the four mixing steps run once per wheel.
// One sample is in work at a time; s_axis_tready is high only while the sequencer idles.
// A finished result sits in the output register, so the next sample may start while
// it waits; the last step stalls only if the previous result is still untaken.
// Reset clears the integrator, the previous error and all configuration registers to their defaults.
module pid_steering_motor_mixer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [pmm_pkg::ERR_W-1:0]           s_axis_tdata,  // [15:0] err_in
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] correction, [35:16] left_fwd_pulse, [55:36] left_rev_pulse,
	// [75:56] right_fwd_pulse, [95:76] right_rev_pulse
	output logic [pmm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pmm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pmm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	pmm_pkg::cfg_t  cfg_q;
	pmm_pkg::ctrl_t ctrl;
	logic           side, out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain        <= pmm_pkg::KP_RST;
			cfg_q.ki_gain        <= pmm_pkg::KI_RST;
			cfg_q.kd_gain        <= pmm_pkg::KD_RST;
			cfg_q.output_limit   <= pmm_pkg::OLIM_RST;
			cfg_q.integral_limit <= pmm_pkg::ILIM_RST;
			cfg_q.base_speed     <= pmm_pkg::BASE_RST;
			cfg_q.pwm_period     <= pmm_pkg::PERIOD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pmm_pkg::REG_KP:     cfg_q.kp_gain <= cfg_data[pmm_pkg::GAIN_W-1:0];
				pmm_pkg::REG_KI:     cfg_q.ki_gain <= cfg_data[pmm_pkg::GAIN_W-1:0];
				pmm_pkg::REG_KD:     cfg_q.kd_gain <= cfg_data[pmm_pkg::GAIN_W-1:0];
				pmm_pkg::REG_OLIM:
					cfg_q.output_limit <= cfg_data[pmm_pkg::LIMIT_W-1:0];
				pmm_pkg::REG_ILIM:
					cfg_q.integral_limit <= cfg_data[pmm_pkg::LIMIT_W-1:0];
				pmm_pkg::REG_BASE:
					cfg_q.base_speed <= signed'(cfg_data[pmm_pkg::SPEED_W-1:0]);
				pmm_pkg::REG_PERIOD:
					cfg_q.pwm_period <= cfg_data[pmm_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	pmm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.side     (side),
		.ctrl     (ctrl)
	);

	pmm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg_q),
		.err_in    (s_axis_tdata),
		.side      (side),
		.out_free  (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the steering PID motor mixer: directed table, then random phases.
module tb_top;

	localparam logic [pmm_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;	// unused index, write must be ignored
	localparam int GAP_MAX      = 18;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES       = 27;
	localparam int PHASE_ITEMS  = 50;

	// Same layout as m_axis_tdata: correction in the lowest bits
	typedef struct packed {
		logic [pmm_pkg::PULSE_W-1:0]      rr;
		logic [pmm_pkg::PULSE_W-1:0]      rf;
		logic [pmm_pkg::PULSE_W-1:0]      lr;
		logic [pmm_pkg::PULSE_W-1:0]      lf;
		logic signed [pmm_pkg::COR_W-1:0] cor;
	} mix_t;

	typedef enum logic {ROW_CFG, ROW_ERR} row_kind_t;
	typedef enum logic [1:0] {GAP_NONE, GAP_SPARSE, GAP_FULL} gap_mode_t;

	typedef struct packed {
		row_kind_t                         kind;
		logic [pmm_pkg::CFG_IDX_W-1:0]     idx;
		logic [pmm_pkg::CFG_DATA_W-1:0]    data;
		logic [pmm_pkg::ERR_W-1:0]         err;
		logic                              typed;
		mix_t                              want;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [pmm_pkg::ERR_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [pmm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pmm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pmm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Mirror of the block's registers and controller state
	pmm_pkg::cfg_t mirror_cfg;
	logic signed [pmm_pkg::ERR_W-1:0] mirror_acc;
	logic signed [pmm_pkg::ERR_W-1:0] mirror_prev;
	mix_t pending_mix[$];

	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_writes = 0;
	gap_mode_t src_mode = GAP_SPARSE;
	gap_mode_t sink_mode = GAP_SPARSE;
	bit hold_req = 1'b0;
	longint walk_err = 0;

	pid_steering_motor_mixer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d results still outstanding", $time, pending_mix.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void mirror_write(logic [pmm_pkg::CFG_IDX_W-1:0] idx,
			logic [pmm_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			pmm_pkg::REG_KP:     mirror_cfg.kp_gain = data[pmm_pkg::GAIN_W-1:0];
			pmm_pkg::REG_KI:     mirror_cfg.ki_gain = data[pmm_pkg::GAIN_W-1:0];
			pmm_pkg::REG_KD:     mirror_cfg.kd_gain = data[pmm_pkg::GAIN_W-1:0];
			pmm_pkg::REG_OLIM:   mirror_cfg.output_limit = data[pmm_pkg::LIMIT_W-1:0];
			pmm_pkg::REG_ILIM:   mirror_cfg.integral_limit = data[pmm_pkg::LIMIT_W-1:0];
			pmm_pkg::REG_BASE:   mirror_cfg.base_speed = data[pmm_pkg::SPEED_W-1:0];
			pmm_pkg::REG_PERIOD: mirror_cfg.pwm_period = data[pmm_pkg::PERIOD_W-1:0];
			default: ;
		endcase
	endfunction

	// H-bridge pair: zero or negative target selects the reverse channel
	function automatic void bridge_pulses(input longint tgt,
			output logic [pmm_pkg::PULSE_W-1:0] fwd, output logic [pmm_pkg::PULSE_W-1:0] rev);
		longint duty;
		logic [pmm_pkg::PULSE_W-1:0] pulse;
		duty = (tgt > 0) ? tgt : -tgt;
		if (duty > pmm_pkg::DUTY_FULL)
			duty = pmm_pkg::DUTY_FULL;
		pulse = pmm_pkg::PULSE_W'((duty * longint'(mirror_cfg.pwm_period)) /
			pmm_pkg::DUTY_FULL);
		fwd = (tgt > 0) ? pulse : '0;
		rev = (tgt > 0) ? '0 : pulse;
	endfunction

	function automatic mix_t mix_predict(logic [pmm_pkg::ERR_W-1:0] err_bits);
		longint e, sum, lim, raw, cor, speed_fx, left_t, right_t;
		mix_t m;
		e = longint'(signed'(err_bits));
		lim = longint'(mirror_cfg.integral_limit);
		sum = longint'(mirror_acc) + e;
		if (sum > lim)
			sum = lim;
		else if (sum < -lim)
			sum = -lim;
		mirror_acc = sum[pmm_pkg::ERR_W-1:0];
		raw = longint'(mirror_cfg.kp_gain) * e
			+ longint'(mirror_cfg.ki_gain) * longint'(mirror_acc)
			+ longint'(mirror_cfg.kd_gain) * (e - longint'(mirror_prev));
		mirror_prev = err_bits;
		// signed division truncates toward zero
		cor = raw / (longint'(1) << pmm_pkg::GAIN_FRAC_BITS);
		lim = longint'(mirror_cfg.output_limit);
		if (cor > lim)
			cor = lim;
		else if (cor < -lim)
			cor = -lim;
		speed_fx = longint'(signed'(mirror_cfg.base_speed)) *
			(longint'(1) << pmm_pkg::ERR_FRAC_BITS);
		left_t = (speed_fx - cor) / (longint'(1) << pmm_pkg::ERR_FRAC_BITS);
		right_t = (speed_fx + cor) / (longint'(1) << pmm_pkg::ERR_FRAC_BITS);
		m.cor = cor[pmm_pkg::COR_W-1:0];
		bridge_pulses(left_t, m.lf, m.lr);
		bridge_pulses(right_t, m.rf, m.rr);
		return m;
	endfunction

	function automatic int draw_gap(gap_mode_t mode);
		case (mode)
			GAP_FULL:   return $urandom_range(0, GAP_MAX);
			GAP_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, GAP_MAX) : 0;
			default:    return 0;
		endcase
	endfunction

	function automatic logic [pmm_pkg::CFG_DATA_W-1:0] pick_reg_value(
			logic [pmm_pkg::CFG_IDX_W-1:0] idx);
		logic [pmm_pkg::CFG_DATA_W-1:0] v;
		int c;
		v = pmm_pkg::CFG_DATA_W'($urandom);	// bits above the register width stay random
		c = $urandom_range(0, 4);
		case (idx)
			pmm_pkg::REG_KP, pmm_pkg::REG_KI, pmm_pkg::REG_KD: begin
				if (c == 0)
					v[pmm_pkg::GAIN_W-1:0] = '0;
				else if (c == 1)
					v[pmm_pkg::GAIN_W-1:0] = '1;
				else if (c <= 3)
					v[pmm_pkg::GAIN_W-1:0] = pmm_pkg::GAIN_W'($urandom_range(0, 8191));
			end
			pmm_pkg::REG_OLIM, pmm_pkg::REG_ILIM: begin
				if (c == 0)
					v[pmm_pkg::LIMIT_W-1:0] = '0;
				else if (c == 1)
					v[pmm_pkg::LIMIT_W-1:0] = '1;
				else if (c <= 3)
					v[pmm_pkg::LIMIT_W-1:0] = pmm_pkg::LIMIT_W'($urandom_range(0, 4095));
			end
			pmm_pkg::REG_BASE: begin
				if (c == 0)
					v[pmm_pkg::SPEED_W-1:0] = 8'd100;
				else if (c == 1)
					v[pmm_pkg::SPEED_W-1:0] = -8'sd100;
				else if (c <= 3)
					v[pmm_pkg::SPEED_W-1:0] =
						pmm_pkg::SPEED_W'(int'($urandom_range(0, 200)) - 100);
			end
			pmm_pkg::REG_PERIOD: begin
				if (c == 0)
					v = '0;
				else if (c == 1)
					v = 20'd1000000;
				else if (c == 2)
					v = pmm_pkg::CFG_DATA_W'($urandom_range(1, 100000));
				else if (c == 3)
					v = 20'd1;
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [pmm_pkg::ERR_W-1:0] pick_err(bit drift);
		longint v;
		int c;
		if (drift) begin
			// slowly wandering error, as from a real steering loop
			walk_err += longint'($urandom_range(0, 1024)) - 512;
			if (walk_err > 32767)
				walk_err = 32767;
			else if (walk_err < -32768)
				walk_err = -32768;
			return walk_err[pmm_pkg::ERR_W-1:0];
		end
		c = $urandom_range(0, 19);
		if (c <= 9)
			v = longint'($urandom_range(0, 2047)) - 1024;
		else if (c <= 13)
			v = longint'($urandom_range(0, 16383)) - 8192;
		else if (c <= 16)
			v = longint'($urandom_range(0, 65535));
		else if (c == 17)
			v = 32767;
		else if (c == 18)
			v = -32768;
		else
			v = 0;
		return v[pmm_pkg::ERR_W-1:0];
	endfunction

	function automatic dir_row_t row_cfg(logic [pmm_pkg::CFG_IDX_W-1:0] idx,
			logic [pmm_pkg::CFG_DATA_W-1:0] data);
		dir_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	function automatic dir_row_t row_err(logic [pmm_pkg::ERR_W-1:0] err);
		dir_row_t row;
		row = '0;
		row.kind = ROW_ERR;
		row.err = err;
		return row;
	endfunction

	function automatic dir_row_t row_chk(logic [pmm_pkg::ERR_W-1:0] err,
			logic [pmm_pkg::PULSE_W-1:0] lf, logic [pmm_pkg::PULSE_W-1:0] lr,
			logic [pmm_pkg::PULSE_W-1:0] rf, logic [pmm_pkg::PULSE_W-1:0] rr);
		dir_row_t row;
		row = row_err(err);
		row.typed = 1'b1;
		row.want = '{rr: rr, rf: rf, lr: lr, lf: lf, cor: '0};
		return row;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// One sample transfer; valid is either re-driven or lowered at the transfer edge
	task automatic send_err(logic [pmm_pkg::ERR_W-1:0] err, bit typed, mix_t typed_want);
		mix_t predicted;
		int gap;
		s_axis_tdata <= err;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		predicted = mix_predict(err);
		pending_mix.push_back(typed ? typed_want : predicted);
		n_items++;
		gap = draw_gap(src_mode);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_mix.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(logic [pmm_pkg::CFG_IDX_W-1:0] idx,
			logic [pmm_pkg::CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		mirror_write(idx, data);
		n_writes++;
	endtask

	// Result side
	initial begin : sink
		mix_t got, want;
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				n = HOLD_CYCLES;
			end else
				n = draw_gap(sink_mode);
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			got = m_axis_tdata;
			n_results++;
			if (pending_mix.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got 0x%h", $time, got);
			end else begin
				want = pending_mix.pop_front();
				check_field("correction", want.cor, got.cor);
				check_field("left_fwd_pulse", want.lf, got.lf);
				check_field("left_rev_pulse", want.lr, got.lr);
				check_field("right_fwd_pulse", want.rf, got.rf);
				check_field("right_rev_pulse", want.rr, got.rr);
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		dir_row_t dir_rows[$];
		int p, r, k;
		bit cfg_open, drift;

		mirror_cfg = '{pmm_pkg::KP_RST, pmm_pkg::KI_RST, pmm_pkg::KD_RST, pmm_pkg::OLIM_RST,
			pmm_pkg::ILIM_RST, pmm_pkg::BASE_RST, pmm_pkg::PERIOD_RST};
		mirror_acc = '0;
		mirror_prev = '0;
		cfg_open = 1'b0;

		// reset settings: zero error leaves both wheels at base speed 20
		dir_rows.push_back(row_chk(16'sd0, 20'd16666, 20'd0, 20'd16666, 20'd0));
		dir_rows.push_back(row_err(16'sd32767));
		dir_rows.push_back(row_err(-16'sd32768));
		dir_rows.push_back(row_err(16'sd1));
		dir_rows.push_back(row_err(-16'sd1));
		dir_rows.push_back(row_err(16'sd256));
		dir_rows.push_back(row_err(-16'sd256));
		dir_rows.push_back(row_err(16'sd0));
		// no gains, zero base speed: zero target gives no pulse at all
		dir_rows.push_back(row_cfg(pmm_pkg::REG_KP, 20'hF0000));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_KI, 20'h00000));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_KD, 20'h10000));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_PERIOD, 20'd1000));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_BASE, 20'h00100));
		dir_rows.push_back(row_chk(16'sd32767, 20'd0, 20'd0, 20'd0, 20'd0));
		// full reverse
		dir_rows.push_back(row_cfg(pmm_pkg::REG_BASE, 20'hABC9C));
		dir_rows.push_back(row_chk(-16'sd32768, 20'd0, 20'd1000, 20'd0, 20'd1000));
		// full forward with a zero period
		dir_rows.push_back(row_cfg(pmm_pkg::REG_BASE, 20'h00064));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_PERIOD, 20'd0));
		dir_rows.push_back(row_chk(16'sd100, 20'd0, 20'd0, 20'd0, 20'd0));
		// out of range index dropped, period at its largest value
		dir_rows.push_back(row_cfg(REG_NONE, 20'h12345));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_PERIOD, 20'hFFFFF));
		dir_rows.push_back(row_chk(16'sd5, 20'hFFFFF, 20'd0, 20'hFFFFF, 20'd0));
		// largest gains with both limits at zero: correction held at zero
		dir_rows.push_back(row_cfg(pmm_pkg::REG_KP, 20'hFFFFF));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_KI, 20'hFFFFF));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_KD, 20'hFFFFF));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_OLIM, 20'h08000));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_ILIM, 20'h00000));
		dir_rows.push_back(row_chk(16'sd32767, 20'hFFFFF, 20'd0, 20'hFFFFF, 20'd0));
		// largest gains and limits, full swings
		dir_rows.push_back(row_cfg(pmm_pkg::REG_OLIM, 20'hF7FFF));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_ILIM, 20'h07FFF));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_BASE, 20'd20));
		dir_rows.push_back(row_cfg(pmm_pkg::REG_PERIOD, 20'd83333));
		dir_rows.push_back(row_err(16'sd32767));
		dir_rows.push_back(row_err(-16'sd32768));
		dir_rows.push_back(row_err(16'sd32767));
		dir_rows.push_back(row_err(16'sd12345));
		dir_rows.push_back(row_err(-16'sd1));

		@(posedge arst_n);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				if (!cfg_open) begin
					drain_results();
					cfg_open = 1'b1;
				end
				reg_write(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 1'b0;
				end
				send_err(dir_rows[i].err, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			drain_results();
			for (r = 0; r < 7; r++)
				if (p == 0 || $urandom_range(0, 1) == 0)
					reg_write(pmm_pkg::CFG_IDX_W'(r),
						pick_reg_value(pmm_pkg::CFG_IDX_W'(r)));
			if ($urandom_range(0, 7) == 0)
				reg_write(REG_NONE, pmm_pkg::CFG_DATA_W'($urandom));
			cfg_valid <= 1'b0;
			src_mode = gap_mode_t'($urandom_range(0, 2));
			sink_mode = gap_mode_t'($urandom_range(0, 2));
			drift = ($urandom_range(0, 2) == 0);
			// one long receiver hold-off while samples keep coming back to back
			if (p == PHASES / 2) begin
				hold_req = 1'b1;
				src_mode = GAP_NONE;
			end
			for (k = 0; k < PHASE_ITEMS; k++)
				send_err(pick_err(drift), 1'b0, '0);
		end

		s_axis_tvalid <= 1'b0;
		while (pending_mix.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d error samples and %0d register writes over %0d settings,",
			n_items, n_writes, PHASES + 7);
		$display("with %0d results checked field by field and %0d mismatches.", n_results, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: pid_steering_motor_mixer_unit.f
rtl/pmm_pkg.sv
rtl/pmm_seq.sv
rtl/pmm_dp.sv
rtl/pid_steering_motor_mixer_unit.sv
verif/tb_top.sv
